// ----- hw/rtl/linked_deque_with_cursor_assert.svh -----
// Assertion macros used by the checker of the linked deque.
`ifndef LINKED_DEQUE_WITH_CURSOR_ASSERT_SVH
`define LINKED_DEQUE_WITH_CURSOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- hw/rtl/ldc_pkg.sv -----
package ldc_pkg;

  // Sizes of the slot store and of the entries.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned LINK_W = SLOT_W + 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned FUNC_W = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PAY_W-1:0]  pay_t;

  // A link that points at no slot.
  localparam link_t NIL = link_t'(DEPTH);

  // Operation codes carried on func.
  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_START      = 4'd4,
    OP_READ       = 4'd5,
    OP_WRITE      = 4'd6,
    OP_ADVANCE    = 4'd7,
    OP_DELETE     = 4'd8
  } op_e;

  // Error codes reported with each result.
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_FULL   = 2'd2,
    ERR_CURSOR = 2'd3
  } err_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;    // first step of an operation that is carried out
    logic upd;     // second step of an operation that is carried out
    logic finish;  // last cycle of every transaction, result is registered
    op_e  op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_empty;
    logic full;
    logic cur_none;
    logic fol_none;
  } stat_t;

  // A link names a real slot unless it holds the null marker.
  function automatic logic is_slot(link_t x);
    return x != NIL;
  endfunction

endpackage

// ----- hw/rtl/ldc_datapath.sv -----
module ldc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ldc_pkg::cmd_t       cmd_i,
  input  ldc_pkg::pay_t       payload_in_i,
  output ldc_pkg::stat_t      stat_o,
  output ldc_pkg::pay_t       payload_out_o,
  output logic                payload_valid_o,
  output logic                list_empty_o,
  output logic                cursor_done_o,
  output ldc_pkg::cnt_t       entry_count_o
);

  // Slot memories, one write and one registered read per cycle each.
  ldc_pkg::pay_t  pay_mem [ldc_pkg::DEPTH];
  ldc_pkg::link_t nxt_mem [ldc_pkg::DEPTH];
  ldc_pkg::link_t prv_mem [ldc_pkg::DEPTH];

  // Free slot stack, read at the top and written above it.
  ldc_pkg::slot_t free_q [ldc_pkg::DEPTH];

  ldc_pkg::link_t head_q, head_d;
  ldc_pkg::link_t tail_q, tail_d;
  ldc_pkg::link_t cur_q, cur_d;
  ldc_pkg::link_t fol_q, fol_d;
  ldc_pkg::cnt_t  fc_q, fc_d;
  ldc_pkg::link_t s_q, s_d;

  ldc_pkg::pay_t  pay_rd_q;
  ldc_pkg::link_t nxt_rd_q;
  ldc_pkg::link_t prv_rd_q;

  ldc_pkg::pay_t  pay_out_q;
  logic           valid_out_q;
  logic           empty_out_q;
  logic           cdone_out_q;
  ldc_pkg::cnt_t  count_out_q;

  logic           pay_we, nxt_we, prv_we, free_we, rd_en;
  ldc_pkg::slot_t pay_wa, nxt_wa, prv_wa, free_wa, rd_addr;
  ldc_pkg::pay_t  pay_wd;
  ldc_pkg::link_t nxt_wd, prv_wd;
  ldc_pkg::slot_t free_wd;
  ldc_pkg::cnt_t  fc_m1;
  ldc_pkg::slot_t take_slot;
  ldc_pkg::pay_t  pay_res;
  logic           valid_res;

  assign fc_m1     = fc_q - ldc_pkg::cnt_t'(1);
  assign take_slot = free_q[fc_m1[ldc_pkg::SLOT_W-1:0]];

  assign stat_o.list_empty = !ldc_pkg::is_slot(head_q);
  assign stat_o.full       = (fc_q == '0);
  assign stat_o.cur_none   = !ldc_pkg::is_slot(cur_q);
  assign stat_o.fol_none   = !ldc_pkg::is_slot(fol_q);

  // Step logic: the first step reads or fills a slot, the second relinks.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    fol_d     = fol_q;
    fc_d      = fc_q;
    s_d       = s_q;
    pay_we    = 1'b0;
    pay_wa    = '0;
    pay_wd    = payload_in_i;
    nxt_we    = 1'b0;
    nxt_wa    = '0;
    nxt_wd    = ldc_pkg::NIL;
    prv_we    = 1'b0;
    prv_wa    = '0;
    prv_wd    = ldc_pkg::NIL;
    free_we   = 1'b0;
    free_wa   = fc_q[ldc_pkg::SLOT_W-1:0];
    free_wd   = s_q[ldc_pkg::SLOT_W-1:0];
    rd_en     = 1'b0;
    rd_addr   = '0;
    pay_res   = '0;
    valid_res = 1'b0;

    if (cmd_i.exec) begin
      case (cmd_i.op)
        ldc_pkg::OP_PUSH_FRONT, ldc_pkg::OP_PUSH_BACK: begin
          s_d    = {1'b0, take_slot};
          fc_d   = fc_m1;
          pay_we = 1'b1;
          pay_wa = take_slot;
          nxt_we = 1'b1;
          nxt_wa = take_slot;
          prv_we = 1'b1;
          prv_wa = take_slot;
          if (cmd_i.op == ldc_pkg::OP_PUSH_FRONT) begin
            nxt_wd = head_q;
          end else begin
            prv_wd = tail_q;
          end
        end
        ldc_pkg::OP_POP_FRONT: begin
          rd_en   = 1'b1;
          rd_addr = head_q[ldc_pkg::SLOT_W-1:0];
          s_d     = head_q;
        end
        ldc_pkg::OP_POP_BACK: begin
          rd_en   = 1'b1;
          rd_addr = tail_q[ldc_pkg::SLOT_W-1:0];
          s_d     = tail_q;
        end
        ldc_pkg::OP_START: begin
          rd_en   = 1'b1;
          rd_addr = head_q[ldc_pkg::SLOT_W-1:0];
        end
        ldc_pkg::OP_READ, ldc_pkg::OP_DELETE: begin
          rd_en   = 1'b1;
          rd_addr = cur_q[ldc_pkg::SLOT_W-1:0];
          s_d     = cur_q;
        end
        ldc_pkg::OP_WRITE: begin
          pay_we = 1'b1;
          pay_wa = cur_q[ldc_pkg::SLOT_W-1:0];
        end
        ldc_pkg::OP_ADVANCE: begin
          rd_en   = 1'b1;
          rd_addr = fol_q[ldc_pkg::SLOT_W-1:0];
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.upd) begin
      case (cmd_i.op)
        ldc_pkg::OP_PUSH_FRONT: begin
          if (ldc_pkg::is_slot(head_q)) begin
            prv_we = 1'b1;
            prv_wa = head_q[ldc_pkg::SLOT_W-1:0];
            prv_wd = s_q;
          end else begin
            tail_d = s_q;
          end
          head_d = s_q;
        end
        ldc_pkg::OP_PUSH_BACK: begin
          if (ldc_pkg::is_slot(tail_q)) begin
            nxt_we = 1'b1;
            nxt_wa = tail_q[ldc_pkg::SLOT_W-1:0];
            nxt_wd = s_q;
          end else begin
            head_d = s_q;
          end
          tail_d = s_q;
        end
        ldc_pkg::OP_POP_FRONT, ldc_pkg::OP_POP_BACK, ldc_pkg::OP_DELETE: begin
          // Unlink the slot and return it to the free stack.
          if (ldc_pkg::is_slot(prv_rd_q)) begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd_q[ldc_pkg::SLOT_W-1:0];
            nxt_wd = nxt_rd_q;
          end else begin
            head_d = nxt_rd_q;
          end
          if (ldc_pkg::is_slot(nxt_rd_q)) begin
            prv_we = 1'b1;
            prv_wa = nxt_rd_q[ldc_pkg::SLOT_W-1:0];
            prv_wd = prv_rd_q;
          end else begin
            tail_d = prv_rd_q;
          end
          free_we = 1'b1;
          fc_d    = fc_q + ldc_pkg::cnt_t'(1);
          if (cmd_i.op == ldc_pkg::OP_DELETE) begin
            fol_d = nxt_rd_q;
            cur_d = ldc_pkg::NIL;
          end else begin
            // A pop keeps the cursor off the removed slot.
            pay_res   = pay_rd_q;
            valid_res = 1'b1;
            if (cur_q == s_q) begin
              cur_d = ldc_pkg::NIL;
              fol_d = ldc_pkg::NIL;
            end else if (fol_q == s_q) begin
              fol_d = nxt_rd_q;
            end
          end
        end
        ldc_pkg::OP_START: begin
          cur_d = head_q;
          fol_d = ldc_pkg::is_slot(head_q) ? nxt_rd_q : ldc_pkg::NIL;
        end
        ldc_pkg::OP_READ: begin
          pay_res   = pay_rd_q;
          valid_res = 1'b1;
        end
        ldc_pkg::OP_ADVANCE: begin
          cur_d = fol_q;
          fol_d = ldc_pkg::is_slot(fol_q) ? nxt_rd_q : ldc_pkg::NIL;
        end
        default: begin
        end
      endcase
    end
  end

  // Slot memories.
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      pay_rd_q <= pay_mem[rd_addr];
      nxt_rd_q <= nxt_mem[rd_addr];
      prv_rd_q <= prv_mem[rd_addr];
    end
  end

  // Free stack, filled with every slot number at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ldc_pkg::DEPTH; i++) begin
        free_q[i] <= ldc_pkg::slot_t'(ldc_pkg::DEPTH - 1 - i);
      end
    end else if (free_we) begin
      free_q[free_wa] <= free_wd;
    end
  end

  // List pointers, cursor and free count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= ldc_pkg::NIL;
      tail_q <= ldc_pkg::NIL;
      cur_q  <= ldc_pkg::NIL;
      fol_q  <= ldc_pkg::NIL;
      fc_q   <= ldc_pkg::cnt_t'(ldc_pkg::DEPTH);
      s_q    <= ldc_pkg::NIL;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cur_q  <= cur_d;
      fol_q  <= fol_d;
      fc_q   <= fc_d;
      s_q    <= s_d;
    end
  end

  // Result registers, loaded in the last cycle of each transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
      empty_out_q <= 1'b1;
      cdone_out_q <= 1'b1;
      count_out_q <= '0;
    end else if (cmd_i.finish) begin
      valid_out_q <= valid_res;
      empty_out_q <= !ldc_pkg::is_slot(head_d);
      cdone_out_q <= !ldc_pkg::is_slot(cur_d);
      count_out_q <= ldc_pkg::cnt_t'(ldc_pkg::DEPTH) - fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pay_out_q <= pay_res;
    end
  end

  assign payload_out_o   = pay_out_q;
  assign payload_valid_o = valid_out_q;
  assign list_empty_o    = empty_out_q;
  assign cursor_done_o   = cdone_out_q;
  assign entry_count_o   = count_out_q;

endmodule

// ----- hw/rtl/ldc_ctrl.sv -----
module ldc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [ldc_pkg::FUNC_W-1:0]  func_i,
  input  ldc_pkg::stat_t              stat_i,
  output logic                        busy,
  output ldc_pkg::cmd_t               cmd_o,
  output logic                        done_o,
  output logic [1:0]                  error_code_o
);

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_e;

  state_e         state_q;
  ldc_pkg::op_e   op_q;
  logic           act_q;
  ldc_pkg::err_e  err_q;
  ldc_pkg::err_e  err_out_q;
  logic           done_q;

  logic           accept;
  logic           known;
  ldc_pkg::err_e  err_d;
  logic           act_d;

  assign accept = start && (state_q == ST_IDLE);

  // Error check of the incoming operation against the current list state.
  always_comb begin
    known = 1'b1;
    err_d = ldc_pkg::ERR_NONE;
    case (func_i)
      ldc_pkg::OP_PUSH_FRONT, ldc_pkg::OP_PUSH_BACK: begin
        if (stat_i.full) begin
          err_d = ldc_pkg::ERR_FULL;
        end
      end
      ldc_pkg::OP_POP_FRONT, ldc_pkg::OP_POP_BACK: begin
        if (stat_i.list_empty) begin
          err_d = ldc_pkg::ERR_EMPTY;
        end
      end
      ldc_pkg::OP_START: begin
      end
      ldc_pkg::OP_READ, ldc_pkg::OP_WRITE, ldc_pkg::OP_DELETE: begin
        if (stat_i.cur_none) begin
          err_d = ldc_pkg::ERR_CURSOR;
        end
      end
      ldc_pkg::OP_ADVANCE: begin
        if (stat_i.cur_none && stat_i.fol_none) begin
          err_d = ldc_pkg::ERR_CURSOR;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
    act_d = known && (err_d == ldc_pkg::ERR_NONE);
  end

  // Commands: the first step runs in the accept cycle, the second one after.
  always_comb begin
    cmd_o.exec   = accept && act_d;
    cmd_o.upd    = (state_q == ST_UPD) && act_q;
    cmd_o.finish = (state_q == ST_UPD);
    cmd_o.op     = accept ? ldc_pkg::op_e'(func_i) : op_q;
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= ldc_pkg::OP_PUSH_FRONT;
      act_q     <= 1'b0;
      err_q     <= ldc_pkg::ERR_NONE;
      err_out_q <= ldc_pkg::ERR_NONE;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= ldc_pkg::op_e'(func_i);
            act_q   <= act_d;
            err_q   <= err_d;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          err_out_q <= err_q;
          done_q    <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q == ST_UPD);
  assign done_o       = done_q;
  assign error_code_o = err_out_q;

endmodule

// ----- hw/rtl/linked_deque_with_cursor.sv -----
// Linked deque with cursor: a list of up to 16 entries of 32 bits, kept in
// linked slots with a free slot stack, pushed and popped at either end and
// walked from front to back by a cursor that can read, overwrite or delete.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; func_i selects the operation and payload_in_i carries push or
// write data. busy is high in the cycle after each accepted transaction.
// Result channel: done_o is registered from the controller's ST_UPD state; it
// rises as busy falls and is high for exactly one cycle, and the result is taken
// while it is high, with payload, flags, entry count and error code beside it.
// The receiver cannot stall it; results are never held back.
// An operation is not overlapped with the next one: its first step reads or fills
// a slot through the synchronous slot memories, its second relinks the
// neighbors and loads the result registers. A new command may be taken in the
// same cycle in which the previous result is shown.
// Reset (rst_ni low, asynchronous) empties the list, clears the cursor and
// refills the free stack at once; slot contents stay undefined until written.
module linked_deque_with_cursor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ldc_pkg::FUNC_W-1:0]  func_i,
  input  logic [ldc_pkg::PAY_W-1:0]   payload_in_i,
  output logic                        done_o,
  output logic [ldc_pkg::PAY_W-1:0]   payload_out_o,
  output logic                        payload_valid_o,
  output logic                        list_empty_o,
  output logic                        cursor_done_o,
  output logic [ldc_pkg::CNT_W-1:0]   entry_count_o,
  output logic [1:0]                  error_code_o
);

  ldc_pkg::cmd_t  cmd;
  ldc_pkg::stat_t stat;

  // Sequencing of each operation.
  ldc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .func_i       (func_i),
    .stat_i       (stat),
    .busy         (busy),
    .cmd_o        (cmd),
    .done_o       (done_o),
    .error_code_o (error_code_o)
  );

  // Slot memories, list pointers and result registers.
  ldc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .payload_in_i    (payload_in_i),
    .stat_o          (stat),
    .payload_out_o   (payload_out_o),
    .payload_valid_o (payload_valid_o),
    .list_empty_o    (list_empty_o),
    .cursor_done_o   (cursor_done_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// ----- hw/rtl/ldc_checker.sv -----
`include "linked_deque_with_cursor_assert.svh"

module ldc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        payload_valid_o,
  input logic                        list_empty_o,
  input logic [ldc_pkg::CNT_W-1:0]   entry_count_o,
  input logic [1:0]                  error_code_o
);

  logic accept;
  logic count_ok;
  logic err_ok;

  // Conditions watched by the properties below.
  assign accept   = start && !busy;
  assign count_ok = (list_empty_o == (entry_count_o == '0)) &&
                    (entry_count_o <= ldc_pkg::cnt_t'(ldc_pkg::DEPTH));
  assign err_ok   = (error_code_o == ldc_pkg::ERR_NONE);

  // An accepted transaction occupies the block for the following cycle.
  `LDC_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after accept")

  // Each accepted transaction yields its result.
  `LDC_ASSERT_IMPL(a_result_latency, accept, ##2 done_o, "result missing after accept")

  // Results are never shown in two consecutive cycles.
  `LDC_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "result strobe repeated")

  // The empty flag agrees with the entry count, which never exceeds the depth.
  `LDC_ASSERT_IMPL(a_empty_count, done_o, count_ok, "empty flag and count disagree")

  // Returned data never comes with an error.
  `LDC_ASSERT_IMPL(a_data_no_err, done_o && payload_valid_o, err_ok, "data returned with error")

endmodule

bind linked_deque_with_cursor ldc_checker u_ldc_checker (.*);
